// ===== design/hgpw_pkg.sv =====
// ----------------------------------------------------------------------------
// hgpw_pkg: shared types and constants
// Widths, register indexes, reset values and pipeline sideband structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hgpw_pkg;

  localparam int SCREEN_WIDTH_DEF  = 1920;
  localparam int SCREEN_HEIGHT_DEF = 1080;

  localparam int XW  = 12;  // coordinate width
  localparam int HW  = 16;  // height width
  localparam int AW  = 24;  // byte address width
  localparam int CDW = 24;  // config data width
  localparam int CIW = 2;   // config index width

  // ratio divider: |dx| << 16 over |span|
  localparam int Q1W     = 28;
  localparam int DIV1_DW = 12;
  // normalize divider: 17 quotient bits over |range|
  localparam int Q2W     = 17;
  localparam int DIV2_DW = 16;

  localparam logic [CIW-1:0] CFG_MIN_HEIGHT   = 2'd0;
  localparam logic [CIW-1:0] CFG_MAX_HEIGHT   = 2'd1;
  localparam logic [CIW-1:0] CFG_LINE_STRIDE  = 2'd2;
  localparam logic [CIW-1:0] CFG_BUFFER_LIMIT = 2'd3;

  localparam logic [HW-1:0] MIN_HEIGHT_RST   = 16'd0;
  localparam logic [HW-1:0] MAX_HEIGHT_RST   = 16'd255;
  localparam logic [15:0]   LINE_STRIDE_RST  = 16'd7680;
  localparam logic [AW-1:0] BUFFER_LIMIT_RST = 24'd7680000;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // gradient segments
  localparam logic [2:0] SEG_RED_BLUE    = 3'd0;
  localparam logic [2:0] SEG_BLUE_CYAN   = 3'd1;
  localparam logic [2:0] SEG_CYAN_GREEN  = 3'd2;
  localparam logic [2:0] SEG_GREEN_YEL   = 3'd3;
  localparam logic [2:0] SEG_YEL_RED     = 3'd4;

  typedef struct packed {
    logic                 zero_span;
    logic                 neg;
    logic signed [HW-1:0] sh;
    logic signed [HW:0]   dh;
    logic                 we;
    logic [AW-1:0]        addr;
  } side1_t;

  typedef struct packed {
    logic          zero_c;
    logic          ovf;
    logic          we;
    logic [AW-1:0] addr;
  } side2_t;

endpackage

// ===== design/hgpw_if.sv =====
// ----------------------------------------------------------------------------
// hgpw_in_if / hgpw_out_if: valid/ready channels
// Pixel word in, colored pixel word out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hgpw_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] start_x;
  logic signed [15:0] start_height;
  logic [11:0] end_x;
  logic signed [15:0] end_height;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;

  modport source (output valid, start_x, start_height, end_x, end_height,
                  pixel_x, pixel_y, input ready);
  modport sink   (input valid, start_x, start_height, end_x, end_height,
                  pixel_x, pixel_y, output ready);
endinterface

interface hgpw_out_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [23:0] byte_address;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;

  modport source (output valid, write_enable, byte_address, red, green, blue,
                  input ready);
  modport sink   (input valid, write_enable, byte_address, red, green, blue,
                  output ready);
endinterface

// ===== design/hgpw_div_cell.sv =====
// ----------------------------------------------------------------------------
// hgpw_div_cell: one restoring-division step
// Takes one numerator bit, emits one quotient bit, passes sideband along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hgpw_div_cell #(
  parameter int NW = 28,
  parameter int DW = 12,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_i,
  input  logic [DW-1:0] rem_i,
  input  logic [NW-1:0] nq_i,
  input  logic [DW-1:0] d_i,
  input  logic [SW-1:0] side_i,
  output logic          v_o,
  output logic [DW-1:0] rem_o,
  output logic [NW-1:0] nq_o,
  output logic [DW-1:0] d_o,
  output logic [SW-1:0] side_o
);

  logic          v_r;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] nq_r, nq_nxt;
  logic [DW-1:0] d_r;
  logic [SW-1:0] side_r;
  logic [DW:0]   trial, diff;
  logic          ge;

  assign trial   = {rem_i, nq_i[NW-1]};
  assign diff    = trial - {1'b0, d_i};
  assign ge      = trial >= {1'b0, d_i};
  assign rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
  assign nq_nxt  = {nq_i[NW-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      nq_r   <= nq_nxt;
      d_r    <= d_i;
      side_r <= side_i;
    end
  end

  assign v_o    = v_r;
  assign rem_o  = rem_r;
  assign nq_o   = nq_r;
  assign d_o    = d_r;
  assign side_o = side_r;

endmodule

// ===== design/height_gradient_pixel_writer.sv =====
// ----------------------------------------------------------------------------
// height_gradient_pixel_writer: height-interpolated rainbow pixel colorer
// Interpolates height along x, normalizes it, maps it to RGB, and forms the
// mirrored framebuffer address with a write flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Fully pipelined: one pixel word accepted every clock unless the output
// stalls. The two divisions are rows of one-bit division cells (28 cells
// for the x ratio, 17 for the normalized height), and those rows set the
// latency. A stall on the output freezes the whole pipeline; in_ch.ready
// drops only while a result waits in the output register and the sink is
// not taking it. Registers may be rewritten only while the block is empty.

module height_gradient_pixel_writer #(
  parameter int SCREEN_WIDTH  = hgpw_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = hgpw_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  hgpw_in_if.sink                  in_ch,
  hgpw_out_if.source               out_ch,
  input  logic                     cfg_we,
  input  logic [hgpw_pkg::CIW-1:0] cfg_index,
  input  logic [hgpw_pkg::CDW-1:0] cfg_data
);

  localparam int Q1W = hgpw_pkg::Q1W;
  localparam int D1W = hgpw_pkg::DIV1_DW;
  localparam int Q2W = hgpw_pkg::Q2W;
  localparam int D2W = hgpw_pkg::DIV2_DW;
  localparam int S1W = $bits(hgpw_pkg::side1_t);
  localparam int S2W = $bits(hgpw_pkg::side2_t);

  localparam logic signed [12:0] SW13  = 13'(SCREEN_WIDTH);
  localparam logic signed [12:0] SH13  = 13'(SCREEN_HEIGHT);
  localparam logic [11:0]        XMAX  = 12'(SCREEN_WIDTH - 1);
  localparam logic [11:0]        YMAX  = 12'(SCREEN_HEIGHT - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [15:0] min_height_r, max_height_r;
  logic [15:0]        line_stride_r;
  logic [23:0]        buffer_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_height_r   <= hgpw_pkg::MIN_HEIGHT_RST;
      max_height_r   <= hgpw_pkg::MAX_HEIGHT_RST;
      line_stride_r  <= hgpw_pkg::LINE_STRIDE_RST;
      buffer_limit_r <= hgpw_pkg::BUFFER_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hgpw_pkg::CFG_MIN_HEIGHT:   min_height_r   <= cfg_data[15:0];
        hgpw_pkg::CFG_MAX_HEIGHT:   max_height_r   <= cfg_data[15:0];
        hgpw_pkg::CFG_LINE_STRIDE:  line_stride_r  <= cfg_data[15:0];
        hgpw_pkg::CFG_BUFFER_LIMIT: buffer_limit_r <= cfg_data[23:0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Global advance: everything moves unless the output word is stuck.
  // --------------------------------------------------------------------------
  logic en;
  logic out_v_r;

  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  // --------------------------------------------------------------------------
  // S0: spans, magnitudes, address and margin checks
  // --------------------------------------------------------------------------
  logic signed [12:0] dx, span, dx_abs, span_abs, yoff, xoff;
  logic signed [29:0] yterm;
  logic signed [30:0] addr;
  logic               in_margin, inbuf;
  hgpw_pkg::side1_t   s0_side;

  assign dx       = $signed({1'b0, in_ch.pixel_x}) - $signed({1'b0, in_ch.start_x});
  assign span     = $signed({1'b0, in_ch.end_x}) - $signed({1'b0, in_ch.start_x});
  assign dx_abs   = dx[12] ? -dx : dx;
  assign span_abs = span[12] ? -span : span;

  assign yoff  = SH13 - $signed({1'b0, in_ch.pixel_y});
  assign xoff  = SW13 - $signed({1'b0, in_ch.pixel_x});
  assign yterm = yoff * $signed({1'b0, line_stride_r});
  assign addr  = 31'(yterm) + 31'($signed({xoff, 2'b00}));

  assign in_margin = (in_ch.pixel_x > 12'd1) && (in_ch.pixel_y > 12'd1) &&
                     (in_ch.pixel_x < XMAX) && (in_ch.pixel_y < YMAX);
  assign inbuf     = !addr[30] && (addr[29:0] < {6'b0, buffer_limit_r});

  always_comb begin
    s0_side.zero_span = (span == '0);
    s0_side.neg       = dx[12] ^ span[12];
    s0_side.sh        = in_ch.start_height;
    s0_side.dh        = $signed({in_ch.end_height[15], in_ch.end_height})
                      - $signed({in_ch.start_height[15], in_ch.start_height});
    s0_side.we        = in_margin && inbuf;
    s0_side.addr      = addr[23:0];
  end

  logic             s0_v_r;
  logic [Q1W-1:0]   s0_num_r;
  logic [D1W-1:0]   s0_d_r;
  hgpw_pkg::side1_t s0_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_num_r  <= {dx_abs[11:0], 16'b0};
      s0_d_r    <= span_abs[11:0];
      s0_side_r <= s0_side;
    end
  end

  // --------------------------------------------------------------------------
  // Ratio divider: row of Q1W cells
  // --------------------------------------------------------------------------
  logic           c1_v    [0:Q1W];
  logic [D1W-1:0] c1_rem  [0:Q1W];
  logic [Q1W-1:0] c1_nq   [0:Q1W];
  logic [D1W-1:0] c1_d    [0:Q1W];
  logic [S1W-1:0] c1_side [0:Q1W];

  assign c1_v[0]    = s0_v_r;
  assign c1_rem[0]  = '0;
  assign c1_nq[0]   = s0_num_r;
  assign c1_d[0]    = s0_d_r;
  assign c1_side[0] = s0_side_r;

  for (genvar i = 0; i < Q1W; i++) begin : g_div1
    hgpw_div_cell #(.NW(Q1W), .DW(D1W), .SW(S1W)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (c1_v[i]),
      .rem_i  (c1_rem[i]),
      .nq_i   (c1_nq[i]),
      .d_i    (c1_d[i]),
      .side_i (c1_side[i]),
      .v_o    (c1_v[i+1]),
      .rem_o  (c1_rem[i+1]),
      .nq_o   (c1_nq[i+1]),
      .d_o    (c1_d[i+1]),
      .side_o (c1_side[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // S1: signed ratio times height delta
  // --------------------------------------------------------------------------
  hgpw_pkg::side1_t   d1_side;
  logic signed [28:0] ratio;
  logic signed [45:0] prod;

  assign d1_side = c1_side[Q1W];
  assign ratio   = d1_side.zero_span ? '0 :
                   d1_side.neg ? -$signed({1'b0, c1_nq[Q1W]}) :
                                  $signed({1'b0, c1_nq[Q1W]});
  assign prod    = ratio * d1_side.dh;

  logic               s1_v_r;
  logic signed [45:0] s1_prod_r;
  logic signed [15:0] s1_sh_r;
  logic               s1_we_r;
  logic [23:0]        s1_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= c1_v[Q1W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod_r <= prod;
      s1_sh_r   <= d1_side.sh;
      s1_we_r   <= d1_side.we;
      s1_addr_r <= d1_side.addr;
    end
  end

  // --------------------------------------------------------------------------
  // S2: numerator h - min*2^16 and height range
  // --------------------------------------------------------------------------
  logic signed [16:0] sh_mn, range_nxt;
  logic signed [47:0] n2_nxt;

  assign sh_mn     = $signed({s1_sh_r[15], s1_sh_r})
                   - $signed({min_height_r[15], min_height_r});
  assign n2_nxt    = 48'(s1_prod_r) + 48'($signed({sh_mn, 16'b0}));
  assign range_nxt = $signed({max_height_r[15], max_height_r})
                   - $signed({min_height_r[15], min_height_r});

  logic               s2_v_r;
  logic signed [47:0] s2_n2_r;
  logic signed [16:0] s2_range_r;
  logic               s2_we_r;
  logic [23:0]        s2_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_n2_r    <= n2_nxt;
      s2_range_r <= range_nxt;
      s2_we_r    <= s1_we_r;
      s2_addr_r  <= s1_addr_r;
    end
  end

  // --------------------------------------------------------------------------
  // S3: magnitudes, overflow (quotient >= 2^17) and sign checks
  // --------------------------------------------------------------------------
  logic [47:0]      an2;
  logic [16:0]      ar17;
  hgpw_pkg::side2_t s3_side;

  assign an2  = s2_n2_r[47] ? 48'(-s2_n2_r) : 48'(s2_n2_r);
  assign ar17 = s2_range_r[16] ? 17'(-s2_range_r) : 17'(s2_range_r);

  always_comb begin
    s3_side.zero_c = (s2_range_r == '0) || (s2_n2_r[47] ^ s2_range_r[16]);
    s3_side.ovf    = an2[47:17] >= {15'b0, ar17[15:0]};
    s3_side.we     = s2_we_r;
    s3_side.addr   = s2_addr_r;
  end

  logic             s3_v_r;
  logic [D2W-1:0]   s3_rem_r;
  logic [Q2W-1:0]   s3_num_r;
  logic [D2W-1:0]   s3_d_r;
  hgpw_pkg::side2_t s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_rem_r  <= an2[32:17];
      s3_num_r  <= an2[16:0];
      s3_d_r    <= ar17[15:0];
      s3_side_r <= s3_side;
    end
  end

  // --------------------------------------------------------------------------
  // Normalize divider: row of Q2W cells
  // --------------------------------------------------------------------------
  logic           c2_v    [0:Q2W];
  logic [D2W-1:0] c2_rem  [0:Q2W];
  logic [Q2W-1:0] c2_nq   [0:Q2W];
  logic [D2W-1:0] c2_d    [0:Q2W];
  logic [S2W-1:0] c2_side [0:Q2W];

  assign c2_v[0]    = s3_v_r;
  assign c2_rem[0]  = s3_rem_r;
  assign c2_nq[0]   = s3_num_r;
  assign c2_d[0]    = s3_d_r;
  assign c2_side[0] = s3_side_r;

  for (genvar j = 0; j < Q2W; j++) begin : g_div2
    hgpw_div_cell #(.NW(Q2W), .DW(D2W), .SW(S2W)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (c2_v[j]),
      .rem_i  (c2_rem[j]),
      .nq_i   (c2_nq[j]),
      .d_i    (c2_d[j]),
      .side_i (c2_side[j]),
      .v_o    (c2_v[j+1]),
      .rem_o  (c2_rem[j+1]),
      .nq_o   (c2_nq[j+1]),
      .d_o    (c2_d[j+1]),
      .side_o (c2_side[j+1])
    );
  end

  // --------------------------------------------------------------------------
  // S4: clamp to [0, 1.0]
  // --------------------------------------------------------------------------
  hgpw_pkg::side2_t d2_side;
  logic [16:0]      c_nxt;

  assign d2_side = c2_side[Q2W];

  always_comb begin
    priority if (d2_side.zero_c) begin
      c_nxt = '0;
    end else if (d2_side.ovf || (c2_nq[Q2W] > hgpw_pkg::ONE_Q16)) begin
      c_nxt = hgpw_pkg::ONE_Q16;
    end else begin
      c_nxt = c2_nq[Q2W];
    end
  end

  logic        s4_v_r;
  logic [16:0] s4_c_r;
  logic        s4_we_r;
  logic [23:0] s4_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= c2_v[Q2W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_c_r    <= c_nxt;
      s4_we_r   <= d2_side.we;
      s4_addr_r <= d2_side.addr;
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: gradient segment, in-segment position, color bytes
  // --------------------------------------------------------------------------
  logic [19:0] c5;
  logic [2:0]  seg;
  logic [19:0] t20;
  logic [16:0] t, tinv;
  logic [24:0] rise_w, fall_w;
  logic [7:0]  rise, fall;
  logic [7:0]  r_nxt, g_nxt, b_nxt;

  assign c5 = {s4_c_r, 2'b00} + {3'b0, s4_c_r};

  always_comb begin
    priority if (c5 >= 20'h40000) begin
      seg = hgpw_pkg::SEG_YEL_RED;
    end else if (c5 >= 20'h30000) begin
      seg = hgpw_pkg::SEG_GREEN_YEL;
    end else if (c5 >= 20'h20000) begin
      seg = hgpw_pkg::SEG_CYAN_GREEN;
    end else if (c5 >= 20'h10000) begin
      seg = hgpw_pkg::SEG_BLUE_CYAN;
    end else begin
      seg = hgpw_pkg::SEG_RED_BLUE;
    end
  end

  assign t20    = c5 - {1'b0, seg, 16'b0};
  assign t      = t20[16:0];
  assign tinv   = hgpw_pkg::ONE_Q16 - t;
  assign rise_w = {t, 8'b0} - {8'b0, t};
  assign fall_w = {tinv, 8'b0} - {8'b0, tinv};
  assign rise   = rise_w[23:16];
  assign fall   = fall_w[23:16];

  always_comb begin
    unique case (seg)
      hgpw_pkg::SEG_RED_BLUE: begin
        r_nxt = fall;   g_nxt = 8'd0;   b_nxt = 8'd255;
      end
      hgpw_pkg::SEG_BLUE_CYAN: begin
        r_nxt = 8'd0;   g_nxt = rise;   b_nxt = 8'd255;
      end
      hgpw_pkg::SEG_CYAN_GREEN: begin
        r_nxt = 8'd0;   g_nxt = 8'd255; b_nxt = fall;
      end
      hgpw_pkg::SEG_GREEN_YEL: begin
        r_nxt = rise;   g_nxt = 8'd255; b_nxt = 8'd0;
      end
      default: begin
        r_nxt = 8'd255; g_nxt = fall;   b_nxt = 8'd0;
      end
    endcase
  end

  logic        out_we_r;
  logic [23:0] out_addr_r;
  logic [7:0]  out_r_r, out_g_r, out_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_we_r   <= s4_we_r;
      out_addr_r <= s4_addr_r;
      out_r_r    <= r_nxt;
      out_g_r    <= g_nxt;
      out_b_r    <= b_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.write_enable = out_we_r;
  assign out_ch.byte_address = out_addr_r;
  assign out_ch.red          = out_r_r;
  assign out_ch.green        = out_g_r;
  assign out_ch.blue         = out_b_r;

`ifndef NO_ASSERTIONS
  // normalized height never leaves [0, 1.0]
  a_c_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r |-> (s4_c_r <= hgpw_pkg::ONE_Q16))
    else $error("normalized height out of range");

  // every gradient color has one full and one empty channel
  a_rainbow: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((out_r_r == 8'd255) || (out_g_r == 8'd255) || (out_b_r == 8'd255)) &&
                ((out_r_r == 8'd0) || (out_g_r == 8'd0) || (out_b_r == 8'd0)))
    else $error("color off the gradient");

  // a stalled pipeline does not take new words
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready) |=> $stable(s4_v_r) && $stable(s0_v_r))
    else $error("pipeline moved during stall");
`endif

endmodule

// ===== verif/tb_height_gradient_pixel_writer.sv =====
// ----------------------------------------------------------------------------
// tb_height_gradient_pixel_writer: self-checking bench for the pixel colorer
// Drives pixel words through the valid/ready channel, predicts the colored
// word for each one, and checks results in order under idle and stall phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_height_gradient_pixel_writer;

  localparam int SW    = hgpw_pkg::SCREEN_WIDTH_DEF;
  localparam int SHT   = hgpw_pkg::SCREEN_HEIGHT_DEF;
  localparam int DRAIN = 80;                 // idle margin after the last result is checked
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [11:0]        sx;
    logic signed [15:0] sh;
    logic [11:0]        ex;
    logic signed [15:0] eh;
    logic [11:0]        px;
    logic [11:0]        py;
  } pix_t;

  typedef struct packed {
    logic        we;
    logic [23:0] addr;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
  } color_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [hgpw_pkg::CIW-1:0] cfg_index;
  logic [hgpw_pkg::CDW-1:0] cfg_data;

  hgpw_in_if  in_ch();
  hgpw_out_if out_ch();

  height_gradient_pixel_writer u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // bench copy of the register file
  logic signed [15:0] min_h, max_h;
  logic [15:0]        stride;
  logic [23:0]        buf_lim;

  color_t pending_colors[$];
  int     errors = 0;
  int     cycle = 0;
  int     n_words, n_checked = 0;
  int     send_idle_pct, stall_pct;
  bit     hold_off;                          // long receiver hold-off

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= LIMIT) begin
      $display("Timeout at cycle %0d", cycle);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Predict the colored word: interpolate height, normalize, rainbow, address.
  function automatic color_t predict_word(pix_t p);
    longint span, ratio, h, range, c, t, addr;
    longint mn, mx;
    int k;
    color_t o;
    mn = min_h;
    mx = max_h;
    span = longint'(p.ex) - longint'(p.sx);
    ratio = 0;
    if (span != 0) ratio = ((longint'(p.px) - longint'(p.sx)) * 65536) / span;
    h = longint'(p.sh) * 65536 + ratio * (longint'(p.eh) - longint'(p.sh));
    range = mx - mn;
    // SV division truncates toward zero, as the magnitude divider in the design does
    c = (range == 0) ? 0 : (h - mn * 65536) / range;
    if (c < 0) c = 0;
    if (c > 65536) c = 65536;
    k = 0;
    while (k < 4 && 5 * c >= longint'(k + 1) * 65536) k++;
    t = 5 * c - longint'(k) * 65536;
    case (k)
      hgpw_pkg::SEG_RED_BLUE: begin
        o.r = 8'((255 * (65536 - t)) / 65536); o.g = 8'd0; o.b = 8'd255;
      end
      hgpw_pkg::SEG_BLUE_CYAN: begin
        o.r = 8'd0; o.g = 8'((255 * t) / 65536); o.b = 8'd255;
      end
      hgpw_pkg::SEG_CYAN_GREEN: begin
        o.r = 8'd0; o.g = 8'd255; o.b = 8'((255 * (65536 - t)) / 65536);
      end
      hgpw_pkg::SEG_GREEN_YEL: begin
        o.r = 8'((255 * t) / 65536); o.g = 8'd255; o.b = 8'd0;
      end
      default: begin
        o.r = 8'd255; o.g = 8'((255 * (65536 - t)) / 65536); o.b = 8'd0;
      end
    endcase
    addr = (longint'(SHT) - longint'(p.py)) * longint'(stride)
         + (longint'(SW) - longint'(p.px)) * 4;
    o.addr = addr[23:0];
    o.we = (p.px > 1 && p.py > 1 && p.px < SW - 1 && p.py < SHT - 1
            && addr >= 0 && addr < longint'(buf_lim));
    return o;
  endfunction

  // One register write per call; cfg_we stays high for back-to-back writes.
  task automatic write_reg(logic [hgpw_pkg::CIW-1:0] idx,
                           logic [hgpw_pkg::CDW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      hgpw_pkg::CFG_MIN_HEIGHT:   min_h   = val[15:0];
      hgpw_pkg::CFG_MAX_HEIGHT:   max_h   = val[15:0];
      hgpw_pkg::CFG_LINE_STRIDE:  stride  = val[15:0];
      hgpw_pkg::CFG_BUFFER_LIMIT: buf_lim = val[23:0];
      default: ;
    endcase
  endtask

  // Ends a run of register writes.
  task automatic cfg_release();
    cfg_we <= 1'b0;
  endtask

  // Send one pixel word; valid stays high across back-to-back words.
  task automatic send_pixel(pix_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.start_x      <= p.sx;
    in_ch.start_height <= p.sh;
    in_ch.end_x        <= p.ex;
    in_ch.end_height   <= p.eh;
    in_ch.pixel_x      <= p.px;
    in_ch.pixel_y      <= p.py;
    do @(posedge clk); while (!in_ch.ready);
    pending_colors.push_back(predict_word(p));
    n_words++;
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Random pixel: mostly on-screen segments, some full-range noise.
  function automatic pix_t rand_pixel();
    pix_t p;
    p.sx = 12'($urandom_range(4095));
    p.ex = ($urandom_range(9) == 0) ? p.sx : 12'($urandom_range(4095));
    p.sh = 16'($urandom);
    p.eh = 16'($urandom);
    if ($urandom_range(3) != 0) begin
      p.sx = 12'($urandom_range(SW - 1));
      p.ex = 12'($urandom_range(SW - 1));
      p.sh = 16'($urandom_range(600) - 100);
      p.eh = 16'($urandom_range(600) - 100);
      p.px = 12'($urandom_range(SW + 2));
      p.py = 12'($urandom_range(SHT + 2));
    end else begin
      p.px = 12'($urandom_range(4095));
      p.py = 12'($urandom_range(4095));
    end
    return p;
  endfunction

  // Receiver: random stall, plus hold-off while hold_off is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    color_t exp_c;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_colors.size() == 0) begin
        $display("%0t: unexpected word addr=%h", $time, out_ch.byte_address);
        errors++;
      end else begin
        exp_c = pending_colors.pop_front();
        n_checked++;
        if (out_ch.write_enable !== exp_c.we) begin
          $display("%0t: write_enable exp %b got %b", $time, exp_c.we,
                   out_ch.write_enable);
          errors++;
        end
        if (out_ch.byte_address !== exp_c.addr) begin
          $display("%0t: byte_address exp %h got %h", $time, exp_c.addr,
                   out_ch.byte_address);
          errors++;
        end
        if (out_ch.red !== exp_c.r) begin
          $display("%0t: red exp %0d got %0d", $time, exp_c.r, out_ch.red);
          errors++;
        end
        if (out_ch.green !== exp_c.g) begin
          $display("%0t: green exp %0d got %0d", $time, exp_c.g, out_ch.green);
          errors++;
        end
        if (out_ch.blue !== exp_c.b) begin
          $display("%0t: blue exp %0d got %0d", $time, exp_c.b, out_ch.blue);
          errors++;
        end
      end
    end
  end

  function automatic pix_t mk(int sx, int sh, int ex, int eh, int px, int py);
    pix_t p;
    p.sx = 12'(sx); p.sh = 16'(sh); p.ex = 12'(ex); p.eh = 16'(eh);
    p.px = 12'(px); p.py = 12'(py);
    return p;
  endfunction

  // Directed: field extremes, every gradient segment, zero span, margins.
  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i <= 6; i++)        // heights 0..255 sweep all segments
      send_pixel(mk(0, 0, 6, 255, i, 500));
    send_pixel(mk(100, 40, 100, 200, 300, 300));     // zero x span
    send_pixel(mk(0, -32768, 4095, 32767, 4095, 4095));
    send_pixel(mk(4095, 32767, 0, -32768, 0, 0));
    send_pixel(mk(10, 0, 20, 255, 100, 100));        // extrapolated above
    send_pixel(mk(10, 0, 20, 255, 0, 100));          // extrapolated below
    send_pixel(mk(0, 51, 10, 51, 1, 1));             // on left/top margin
    send_pixel(mk(0, 102, 10, 102, 2, 2));
    send_pixel(mk(0, 153, 10, 153, SW - 2, SHT - 2));
    send_pixel(mk(0, 204, 10, 204, SW - 1, SHT - 1));
    send_pixel(mk(0, 100, 10, 100, 1000, 4095));     // negative address
    send_pixel(mk(0, 100, 10, 100, 4095, 500));
    send_pixel(mk(4095, 0, 0, 0, 2048, 2048));
    go_idle();
  endtask

  // Register settings, including zero and reversed height range.
  task automatic test_config_settings();
    write_reg(hgpw_pkg::CFG_MIN_HEIGHT, 24'h008000);
    write_reg(hgpw_pkg::CFG_MAX_HEIGHT, 24'h007FFF);
    write_reg(hgpw_pkg::CFG_LINE_STRIDE, 24'h00FFFF);
    write_reg(hgpw_pkg::CFG_BUFFER_LIMIT, 24'hFFFFFF);
    cfg_release();
    for (int i = 0; i < 60; i++) send_pixel(rand_pixel());
    go_idle();
    write_reg(hgpw_pkg::CFG_MIN_HEIGHT, 24'h000064);            // zero range
    write_reg(hgpw_pkg::CFG_MAX_HEIGHT, 24'h000064);
    write_reg(hgpw_pkg::CFG_LINE_STRIDE, 24'h000000);
    write_reg(hgpw_pkg::CFG_BUFFER_LIMIT, 24'h000000);
    cfg_release();
    for (int i = 0; i < 40; i++) send_pixel(rand_pixel());
    go_idle();
    write_reg(hgpw_pkg::CFG_MIN_HEIGHT, 24'h0001F4);            // reversed range
    write_reg(hgpw_pkg::CFG_MAX_HEIGHT, 24'h00FF9C);
    write_reg(hgpw_pkg::CFG_LINE_STRIDE, 24'd7680);
    write_reg(hgpw_pkg::CFG_BUFFER_LIMIT, 24'd4000000);
    cfg_release();
    for (int i = 0; i < 60; i++) send_pixel(rand_pixel());
    go_idle();
    write_reg(hgpw_pkg::CFG_MIN_HEIGHT, 24'hFFFF9C);            // upper bits ignored
    write_reg(hgpw_pkg::CFG_MAX_HEIGHT, 24'h0001F4);
    write_reg(hgpw_pkg::CFG_BUFFER_LIMIT, 24'd7680000);
    cfg_release();
    go_idle();
  endtask

  task automatic test_random_phases();
    int idle_tab[4]  = '{0, 71, 0, 32};
    int stall_tab[4] = '{0, 0, 71, 32};
    for (int ph = 0; ph < 8; ph++) begin
      send_idle_pct = idle_tab[ph % 4];
      stall_pct = stall_tab[ph % 4];
      for (int i = 0; i < 200; i++) send_pixel(rand_pixel());
    end
    send_idle_pct = 0;
    stall_pct = 0;
    go_idle();   // sender pauses until every result is in
  endtask

  // Receiver holds off long enough for the pipeline to fill and stall input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 120; i++) send_pixel(rand_pixel());
    join
    go_idle();
  endtask

  initial begin
    n_words = 0;
    hold_off = 1'b0;
    send_idle_pct = 0; stall_pct = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.start_x = '0; in_ch.start_height = '0;
    in_ch.end_x = '0; in_ch.end_height = '0;
    in_ch.pixel_x = '0; in_ch.pixel_y = '0;
    min_h = hgpw_pkg::MIN_HEIGHT_RST; max_h = hgpw_pkg::MAX_HEIGHT_RST;
    stride = hgpw_pkg::LINE_STRIDE_RST; buf_lim = hgpw_pkg::BUFFER_LIMIT_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_config_settings();
    test_random_phases();
    test_backpressure();

    $display("Checked %0d of %0d pixel words across idle, stall and hold-off phases,",
             n_checked, n_words);
    $display("with extreme, zero and reversed height ranges and address limits.");
    if (errors == 0 && pending_colors.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d words outstanding", errors,
               pending_colors.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== height_gradient_pixel_writer.f =====
design/hgpw_pkg.sv
design/hgpw_if.sv
design/hgpw_div_cell.sv
design/height_gradient_pixel_writer.sv
verif/tb_height_gradient_pixel_writer.sv
